/* rtl/core/vds_pkg.sv */
package vds_pkg;

	localparam int VOLT_W  = 16;
	localparam int TS_W    = 64;
	localparam int INT_W   = 32;
	localparam int SUM_W   = 48;
	localparam int TALLY_W = 20;
	localparam int ACC_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIP_DEPTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST_BAND  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AVG_WEIGHT = 2'd2;

	localparam logic [CFG_W-1:0] DIP_DEPTH_RST  = 16'd410;
	localparam logic [CFG_W-1:0] HYST_BAND_RST  = 16'd123;
	localparam logic [CFG_W-1:0] AVG_WEIGHT_RST = 16'd66;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLOSE  = 1'b1;

	localparam logic [VOLT_W-1:0]  VOLT_MAX     = '1;
	localparam logic [INT_W-1:0]   INTERVAL_MAX = '1;
	localparam logic [SUM_W-1:0]   TOTAL_MAX    = '1;
	localparam logic [TALLY_W-1:0] TALLY_MAX    = '1;

	typedef struct packed {
		logic              kind;
		logic [VOLT_W-1:0] sample_volts;
		logic [TS_W-1:0]   timestamp_ns;
	} in_item_t;

	typedef struct packed {
		logic [VOLT_W-1:0]  min_volts;
		logic [VOLT_W-1:0]  max_volts;
		logic [VOLT_W-1:0]  average_volts;
		logic [INT_W-1:0]   min_interval_ns;
		logic [INT_W-1:0]   max_interval_ns;
		logic [SUM_W-1:0]   interval_sum_ns;
		logic [TALLY_W-1:0] window_samples;
		logic [TALLY_W-1:0] window_dips;
	} out_item_t;

endpackage

/* rtl/core/vds_avg.sv */
// Moving average update: acc' = (acc * (1 - w) + (v << 16) * w) >> 16, seeded by the
// first sample.
module vds_avg (
	input  logic [vds_pkg::ACC_W-1:0]  acc,
	input  logic                       seeded,
	input  logic [vds_pkg::VOLT_W-1:0] volts,
	input  logic [vds_pkg::CFG_W-1:0]  weight,
	output logic [vds_pkg::ACC_W-1:0]  acc_next
);

	localparam int INV_W = vds_pkg::CFG_W + 1;
	localparam int VW_W  = vds_pkg::VOLT_W + vds_pkg::CFG_W;
	localparam int MIX_W = vds_pkg::ACC_W + INV_W;

	logic [INV_W-1:0] inv_weight;
	logic [MIX_W-1:0] old_part;
	logic [VW_W-1:0]  new_part;
	logic [MIX_W-1:0] mix;

	always_comb begin
		inv_weight = {1'b1, {vds_pkg::CFG_W{1'b0}}} - {1'b0, weight};
		old_part   = {{INV_W{1'b0}}, acc} * {{vds_pkg::ACC_W{1'b0}}, inv_weight};
		new_part   = {{vds_pkg::CFG_W{1'b0}}, volts} * {{vds_pkg::VOLT_W{1'b0}}, weight};
		mix        = old_part
		           + {{(MIX_W - VW_W - vds_pkg::FRAC_W){1'b0}}, new_part,
		              {vds_pkg::FRAC_W{1'b0}}};
		if (seeded) begin
			acc_next = mix[vds_pkg::FRAC_W +: vds_pkg::ACC_W];
		end else begin
			acc_next = {volts, {vds_pkg::FRAC_W{1'b0}}};
		end
	end

endmodule

/* rtl/core/voltage_dip_statistics.sv */
// Voltage dip statistics.
// Input channel sample_valid / sample_stall / sample carries items of two kinds:
// a voltage sample (Q4.12 volts plus a 64-bit ns timestamp) or a close-window item.
// A sample updates the moving average, window extremes, interval statistics, counts
// and the dip detector; it produces no report. A close-window item produces one
// report on report_valid / report_stall / report and clears the window statistics;
// average, dip state and previous timestamp carry over to the next window.
// Each item waits in the input register and is processed in a single pass; a report
// is registered as its close-window item leaves that register. One item per cycle
// is accepted sustained; while report_stall holds a report, samples keep flowing,
// but a second close-window item waits in the input register, and sample_stall rises.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready and
// should be written only while the block is idle.
// Reset clears the average, the dip state and the window statistics, and loads the
// default dip depth, hysteresis band and averaging weight.
module voltage_dip_statistics (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  vds_pkg::in_item_t             sample,
	output logic                          report_valid,
	input  logic                          report_stall,
	output vds_pkg::out_item_t            report,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vds_pkg::CFG_W-1:0]     cfg_data
);

	localparam int VW  = vds_pkg::VOLT_W;
	localparam int TW  = vds_pkg::TS_W;
	localparam int IW  = vds_pkg::INT_W;
	localparam int SW  = vds_pkg::SUM_W;
	localparam int CW  = vds_pkg::TALLY_W;

	logic [vds_pkg::CFG_W-1:0] dip_depth_q;
	logic [vds_pkg::CFG_W-1:0] hyst_band_q;
	logic [vds_pkg::CFG_W-1:0] avg_weight_q;

	logic              valid_s1;
	vds_pkg::in_item_t item_s1;

	logic [vds_pkg::ACC_W-1:0] acc_q;
	logic                      seeded_q;
	logic                      in_dip_q;
	logic [VW-1:0]             dip_level_q;
	logic [TW-1:0]             prev_ts_q;
	logic                      have_prev_q;
	logic [VW-1:0]             low_volts_q;
	logic [VW-1:0]             high_volts_q;
	logic [IW-1:0]             low_int_q;
	logic [IW-1:0]             high_int_q;
	logic [SW-1:0]             total_q;
	logic [CW-1:0]             samples_q;
	logic [CW-1:0]             dips_q;

	logic                      advance;
	logic                      is_close;
	logic [vds_pkg::ACC_W-1:0] acc_next;
	logic [VW-1:0]             avg_next;
	logic [TW-1:0]             delta;
	logic [IW-1:0]             delta_sat;
	logic [TW-1:0]             room;
	logic                      total_sat;
	logic                      dip_start;
	logic                      dip_end;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dip_depth_q  <= vds_pkg::DIP_DEPTH_RST;
			hyst_band_q  <= vds_pkg::HYST_BAND_RST;
			avg_weight_q <= vds_pkg::AVG_WEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vds_pkg::CFG_DIP_DEPTH:  dip_depth_q  <= cfg_data;
				vds_pkg::CFG_HYST_BAND:  hyst_band_q  <= cfg_data;
				vds_pkg::CFG_AVG_WEIGHT: avg_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_close     = (item_s1.kind == vds_pkg::KIND_CLOSE);
	assign advance      = valid_s1 && (!is_close || !report_valid || !report_stall);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			item_s1 <= sample;
		end
	end

	vds_avg u_avg (
		.acc      (acc_q),
		.seeded   (seeded_q),
		.volts    (item_s1.sample_volts),
		.weight   (avg_weight_q),
		.acc_next (acc_next)
	);

	always_comb begin
		avg_next = acc_next[vds_pkg::FRAC_W +: VW];
		if (item_s1.timestamp_ns >= prev_ts_q) begin
			delta = item_s1.timestamp_ns - prev_ts_q;
		end else begin
			delta = '0;
		end
		delta_sat = (|delta[TW-1:IW]) ? vds_pkg::INTERVAL_MAX : delta[IW-1:0];
		room      = {{(TW-SW){1'b0}}, vds_pkg::TOTAL_MAX - total_q};
		total_sat = (delta >= room);
		dip_start = ({1'b0, item_s1.sample_volts} + {1'b0, dip_depth_q}) < {1'b0, avg_next};
		dip_end   = {1'b0, item_s1.sample_volts} > ({1'b0, dip_level_q} + {1'b0, hyst_band_q});
	end

	// persistent state: average, dip detector, previous timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			seeded_q    <= 1'b0;
			in_dip_q    <= 1'b0;
			dip_level_q <= '0;
			prev_ts_q   <= '0;
			have_prev_q <= 1'b0;
		end else if (advance && !is_close) begin
			acc_q       <= acc_next;
			seeded_q    <= 1'b1;
			prev_ts_q   <= item_s1.timestamp_ns;
			have_prev_q <= 1'b1;
			if (!in_dip_q) begin
				if (dip_start) begin
					in_dip_q    <= 1'b1;
					dip_level_q <= avg_next - dip_depth_q;
				end
			end else if (dip_end) begin
				in_dip_q <= 1'b0;
			end
		end
	end

	// window statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_volts_q  <= vds_pkg::VOLT_MAX;
			high_volts_q <= '0;
			low_int_q    <= vds_pkg::INTERVAL_MAX;
			high_int_q   <= '0;
			total_q      <= '0;
			samples_q    <= '0;
			dips_q       <= '0;
		end else if (advance) begin
			if (is_close) begin
				low_volts_q  <= vds_pkg::VOLT_MAX;
				high_volts_q <= '0;
				low_int_q    <= vds_pkg::INTERVAL_MAX;
				high_int_q   <= '0;
				total_q      <= '0;
				samples_q    <= '0;
				dips_q       <= '0;
			end else begin
				if (item_s1.sample_volts < low_volts_q) begin
					low_volts_q <= item_s1.sample_volts;
				end
				if (item_s1.sample_volts > high_volts_q) begin
					high_volts_q <= item_s1.sample_volts;
				end
				if (have_prev_q) begin
					if (delta_sat < low_int_q) begin
						low_int_q <= delta_sat;
					end
					if (delta_sat > high_int_q) begin
						high_int_q <= delta_sat;
					end
					if (total_sat) begin
						total_q <= vds_pkg::TOTAL_MAX;
					end else begin
						total_q <= total_q + delta[SW-1:0];
					end
				end
				if (samples_q != vds_pkg::TALLY_MAX) begin
					samples_q <= samples_q + 1'b1;
				end
				if (!in_dip_q && dip_start && dips_q != vds_pkg::TALLY_MAX) begin
					dips_q <= dips_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid <= 1'b0;
		end else if (advance && is_close) begin
			report_valid <= 1'b1;
		end else if (!report_stall) begin
			report_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_close) begin
			report.min_volts       <= low_volts_q;
			report.max_volts       <= high_volts_q;
			report.average_volts   <= acc_q[vds_pkg::FRAC_W +: VW];
			report.min_interval_ns <= low_int_q;
			report.max_interval_ns <= high_int_q;
			report.interval_sum_ns <= total_q;
			report.window_samples  <= samples_q;
			report.window_dips     <= dips_q;
		end
	end

endmodule

/* rtl/core/vds_checker.sv */
module vds_assertions (
	input logic               clk,
	input logic               arst_n,
	input logic               report_valid,
	input logic               report_stall,
	input vds_pkg::out_item_t report
);

	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_stall |=> report_valid && $stable(report))
		else $error("stalled report changed");

	// any window with samples has a consistent voltage range
	a_volt_order: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.window_samples != '0 |->
			report.min_volts <= report.max_volts)
		else $error("window min above max");

	a_dips_bound: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> report.window_dips <= report.window_samples)
		else $error("more dips than samples");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.window_samples == '0 |->
			report.min_volts == vds_pkg::VOLT_MAX && report.max_volts == '0 &&
			report.min_interval_ns == vds_pkg::INTERVAL_MAX &&
			report.max_interval_ns == '0 && report.interval_sum_ns == '0)
		else $error("empty window report not cleared");

endmodule

bind voltage_dip_statistics vds_assertions u_vds_assertions (.*);

/* verif/vds_checker.sv */
`timescale 1ns / 100ps
module vds_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  vds_pkg::in_item_t             sample,
	input  logic                          report_valid,
	input  logic                          report_stall,
	input  vds_pkg::out_item_t            report,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [vds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vds_pkg::CFG_W-1:0]     cfg_data,
	output int                            mismatches,
	output int                            reports_due
);

	// configuration copy
	logic [15:0] dip_depth, hyst_band, avg_weight;

	// persistent state
	logic [31:0] avg_acc;
	bit          seeded, in_dip, have_last;
	logic [15:0] dip_level;
	logic [63:0] last_ts;

	// window statistics
	logic [15:0] low_v, high_v;
	logic [31:0] low_iv, high_iv;
	logic [47:0] iv_sum;
	logic [19:0] n_samples, n_dips;

	vds_pkg::out_item_t window_reports[$];
	int reports_seen = 0;

	task automatic clear_window_stats;
		low_v     = vds_pkg::VOLT_MAX;
		high_v    = '0;
		low_iv    = vds_pkg::INTERVAL_MAX;
		high_iv   = '0;
		iv_sum    = '0;
		n_samples = '0;
		n_dips    = '0;
	endtask

	function automatic bit field_differs(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			if (mismatches < 10)
				$display("report %0d %s: expected %0h, got %0h", reports_seen, name,
					want_v, got_v);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		logic [15:0]        v;
		logic [63:0]        ts;
		logic [63:0]        mix;
		logic [63:0]        gap;
		logic [31:0]        gap_sat;
		logic [15:0]        avg_now;
		vds_pkg::out_item_t want;
		bit                 bad;

		if (!arst_n) begin
			dip_depth  = vds_pkg::DIP_DEPTH_RST;
			hyst_band  = vds_pkg::HYST_BAND_RST;
			avg_weight = vds_pkg::AVG_WEIGHT_RST;
			avg_acc    = '0;
			seeded     = 1'b0;
			in_dip     = 1'b0;
			dip_level  = '0;
			last_ts    = '0;
			have_last  = 1'b0;
			clear_window_stats();
			window_reports.delete();
			mismatches  = 0;
			reports_due = 0;
		end else begin
			// compare first, so a stray report is never matched by a same-edge prediction
			if (report_valid && !report_stall) begin
				if (window_reports.size() == 0) begin
					if (mismatches < 10)
						$display("report %0d arrived with none expected", reports_seen);
					mismatches++;
				end else begin
					want = window_reports.pop_front();
					bad = 1'b0;
					bad |= field_differs("min_volts", want.min_volts, report.min_volts);
					bad |= field_differs("max_volts", want.max_volts, report.max_volts);
					bad |= field_differs("average_volts", want.average_volts,
						report.average_volts);
					bad |= field_differs("min_interval_ns", want.min_interval_ns,
						report.min_interval_ns);
					bad |= field_differs("max_interval_ns", want.max_interval_ns,
						report.max_interval_ns);
					bad |= field_differs("interval_sum_ns", want.interval_sum_ns,
						report.interval_sum_ns);
					bad |= field_differs("window_samples", want.window_samples,
						report.window_samples);
					bad |= field_differs("window_dips", want.window_dips, report.window_dips);
					if (bad)
						mismatches++;
				end
				reports_seen++;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vds_pkg::CFG_DIP_DEPTH:  dip_depth  = cfg_data;
					vds_pkg::CFG_HYST_BAND:  hyst_band  = cfg_data;
					vds_pkg::CFG_AVG_WEIGHT: avg_weight = cfg_data;
					default: ;
				endcase
			end

			if (sample_valid && !sample_stall) begin
				if (sample.kind == vds_pkg::KIND_CLOSE) begin
					want.min_volts       = low_v;
					want.max_volts       = high_v;
					want.average_volts   = avg_acc[31:16];
					want.min_interval_ns = low_iv;
					want.max_interval_ns = high_iv;
					want.interval_sum_ns = iv_sum;
					want.window_samples  = n_samples;
					want.window_dips     = n_dips;
					window_reports.push_back(want);
					clear_window_stats();
				end else begin
					v  = sample.sample_volts;
					ts = sample.timestamp_ns;
					if (v < low_v)
						low_v = v;
					if (v > high_v)
						high_v = v;

					if (!seeded) begin
						avg_acc = {v, 16'd0};
						seeded  = 1'b1;
					end else begin
						mix = {32'd0, avg_acc} * (64'd65536 - {48'd0, avg_weight})
							+ {32'd0, v, 16'd0} * {48'd0, avg_weight};
						avg_acc = mix[47:16];
					end

					if (have_last) begin
						gap = (ts >= last_ts) ? ts - last_ts : 64'd0;
						gap_sat = (gap[63:32] != 0) ? vds_pkg::INTERVAL_MAX : gap[31:0];
						if (gap_sat < low_iv)
							low_iv = gap_sat;
						if (gap_sat > high_iv)
							high_iv = gap_sat;
						if (gap >= {16'd0, vds_pkg::TOTAL_MAX} - {16'd0, iv_sum})
							iv_sum = vds_pkg::TOTAL_MAX;
						else
							iv_sum = iv_sum + gap[47:0];
					end
					last_ts   = ts;
					have_last = 1'b1;

					// dip detector runs on the freshly updated average
					avg_now = avg_acc[31:16];
					if (!in_dip) begin
						if ({1'b0, v} + {1'b0, dip_depth} < {1'b0, avg_now}) begin
							dip_level = avg_now - dip_depth;
							in_dip    = 1'b1;
							if (n_dips != vds_pkg::TALLY_MAX)
								n_dips = n_dips + 1'b1;
						end
					end else if ({1'b0, v} > {1'b0, dip_level} + {1'b0, hyst_band}) begin
						in_dip = 1'b0;
					end

					if (n_samples != vds_pkg::TALLY_MAX)
						n_samples = n_samples + 1'b1;
				end
			end
			reports_due = window_reports.size();
		end
	end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
module tb;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_stall;
	vds_pkg::in_item_t             sample       = '0;
	logic                          report_valid;
	logic                          report_stall = 1'b0;
	vds_pkg::out_item_t            report;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic [vds_pkg::CFG_IDX_W-1:0] cfg_index    = vds_pkg::CFG_DIP_DEPTH;
	logic [vds_pkg::CFG_W-1:0]     cfg_data     = '0;
	int                            mismatches;
	int                            reports_due;
	bit                            jitter       = 1'b1;
	logic [63:0]                   now_ts       = '0;

	always #4 clk = ~clk;

	voltage_dip_statistics dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	vds_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.reports_due  (reports_due)
	);

	initial begin
		#50_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// report side backpressure in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (jitter && $urandom_range(0, 3) == 0) begin
				report_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				report_stall <= 1'b0;
			end
		end
	end

	task automatic push_item(input vds_pkg::in_item_t it);
		if (jitter && $urandom_range(0, 4) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= it;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic sample_at(input logic [15:0] v, input logic [63:0] ts);
		vds_pkg::in_item_t it;
		it.kind         = vds_pkg::KIND_SAMPLE;
		it.sample_volts = v;
		it.timestamp_ns = ts;
		push_item(it);
		now_ts = ts;
	endtask

	// payload of a close item is don't-care, so randomize it
	task automatic close_window;
		vds_pkg::in_item_t it;
		it.kind         = vds_pkg::KIND_CLOSE;
		it.sample_volts = 16'($urandom);
		it.timestamp_ns = {$urandom, $urandom};
		push_item(it);
	endtask

	task automatic drain;
		sample_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		// a trailing sample may still be in the pipe
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [vds_pkg::CFG_IDX_W-1:0] idx,
			input logic [vds_pkg::CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [vds_pkg::CFG_W-1:0] depth,
			input logic [vds_pkg::CFG_W-1:0] band, input logic [vds_pkg::CFG_W-1:0] weight);
		cfg_valid <= 1'b1;
		put_reg(vds_pkg::CFG_DIP_DEPTH, depth);
		put_reg(vds_pkg::CFG_HYST_BAND, band);
		put_reg(vds_pkg::CFG_AVG_WEIGHT, weight);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [15:0] base;
		logic [15:0] v;
		logic [63:0] ts;
		int          pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset configuration
		close_window;                        // empty window, average unseeded
		sample_at(16'hFFFF, 64'd0);          // seeds the average, no interval yet
		sample_at(16'h0000, 64'd0);          // zero interval, deep dip
		sample_at(16'hFFFF, '1);             // huge interval saturates
		sample_at(16'h1234, 64'd5);          // timestamp goes backwards
		close_window;
		sample_at(16'h8000, 64'h0000_0001_0000_0000);
		sample_at(16'h8000, 64'h0000_0002_0000_0000);  // exactly 2^32 apart
		sample_at(16'h0001, 64'h0000_0002_0000_0010);
		sample_at(16'hF000, 64'h0000_0002_0000_0011);
		close_window;
		drain;

		// zero depth and band, near-full weight
		set_config(16'h0000, 16'h0000, 16'hFFFF);
		sample_at(16'h4000, now_ts + 64'd3);
		sample_at(16'h3FFF, now_ts + 64'd3);
		sample_at(16'h0000, now_ts + 64'd1);
		sample_at(16'hFFFF, now_ts + 64'd1);
		close_window;
		drain;

		// zero weight: average frozen, depth too large to ever dip
		set_config(16'hFFFF, 16'hFFFF, 16'h0000);
		sample_at(16'h0000, now_ts + 64'd7);
		sample_at(16'hFFFF, now_ts + 64'd7);
		sample_at(16'h0000, now_ts + 64'd9);
		close_window;
		close_window;
		drain;

		for (int phase = 0; phase < 5; phase++) begin
			drain;
			case (phase)
				0: set_config(vds_pkg::DIP_DEPTH_RST, vds_pkg::HYST_BAND_RST,
					vds_pkg::AVG_WEIGHT_RST);
				1: set_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 600)),
					16'($urandom_range(256, 8192)));
				2: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
				3: set_config(16'($urandom_range(0, 800)), 16'($urandom_range(0, 200)),
					16'($urandom_range(8192, 65535)));
				default: set_config(16'($urandom_range(100, 1500)),
					16'($urandom_range(0, 400)), 16'($urandom_range(1024, 16384)));
			endcase
			jitter = (phase != 4);
			base = 16'($urandom_range(0, 65535));
			for (int i = 0; i < 400; i++) begin
				if (phase == 2 && i == 200)
					drain;
				if ($urandom_range(0, 99) < 8) begin
					close_window;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 80)
						ts = now_ts + 64'($urandom_range(1, 5000));
					else if (pick < 88)
						ts = now_ts;
					else if (pick < 94)
						ts = now_ts + ({$urandom, $urandom} >> $urandom_range(0, 40));
					else
						ts = now_ts - 64'($urandom_range(1, 100000));

					pick = $urandom_range(0, 99);
					if (pick < 70)
						v = base + 16'($urandom_range(0, 600)) - 16'd300;
					else if (pick < 85)
						v = base - 16'($urandom_range(300, 3000));
					else if (pick < 93)
						v = 16'($urandom_range(0, 65535));
					else
						v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					sample_at(v, ts);
					if ($urandom_range(0, 49) == 0)
						base = 16'($urandom_range(0, 65535));
				end
			end
		end
		drain;

		if (mismatches == 0 && reports_due == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
